// File: src/sixteen_bit_alu_condition_codes_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sixteen-bit ALU execute stage
// Concurrent property wrappers, clocked on clk and gated by rst.
// ---------------------------------------------------------------------------
`ifndef SIXTEEN_BIT_ALU_CONDITION_CODES_MACROS_SVH
`define SIXTEEN_BIT_ALU_CONDITION_CODES_MACROS_SVH

// Same-cycle implication
`define SBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sba_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_pkg
// Shared operation codes, branch conditions, beat layouts and the branch
// condition truth table for the ALU execute stage.
// ---------------------------------------------------------------------------
package sba_pkg;

  // Operation codes
  localparam logic [4:0] CMD_MOV    = 5'd0;
  localparam logic [4:0] CMD_CMP    = 5'd1;
  localparam logic [4:0] CMD_BIT    = 5'd2;
  localparam logic [4:0] CMD_BIC    = 5'd3;
  localparam logic [4:0] CMD_BIS    = 5'd4;
  localparam logic [4:0] CMD_ADD    = 5'd5;
  localparam logic [4:0] CMD_SUB    = 5'd6;
  localparam logic [4:0] CMD_CLR    = 5'd7;
  localparam logic [4:0] CMD_COM    = 5'd8;
  localparam logic [4:0] CMD_INC    = 5'd9;
  localparam logic [4:0] CMD_DEC    = 5'd10;
  localparam logic [4:0] CMD_NEG    = 5'd11;
  localparam logic [4:0] CMD_ADC    = 5'd12;
  localparam logic [4:0] CMD_SBC    = 5'd13;
  localparam logic [4:0] CMD_TST    = 5'd14;
  localparam logic [4:0] CMD_ROR    = 5'd15;
  localparam logic [4:0] CMD_ROL    = 5'd16;
  localparam logic [4:0] CMD_ASR    = 5'd17;
  localparam logic [4:0] CMD_ASL    = 5'd18;
  localparam logic [4:0] CMD_SWAB   = 5'd19;
  localparam logic [4:0] CMD_CCC    = 5'd20;
  localparam logic [4:0] CMD_SCC    = 5'd21;
  localparam logic [4:0] CMD_BRANCH = 5'd22;

  // Branch conditions
  localparam logic [3:0] BC_BR   = 4'd0;
  localparam logic [3:0] BC_BNE  = 4'd1;
  localparam logic [3:0] BC_BEQ  = 4'd2;
  localparam logic [3:0] BC_BGE  = 4'd3;
  localparam logic [3:0] BC_BLT  = 4'd4;
  localparam logic [3:0] BC_BGT  = 4'd5;
  localparam logic [3:0] BC_BLE  = 4'd6;
  localparam logic [3:0] BC_BPL  = 4'd7;
  localparam logic [3:0] BC_BMI  = 4'd8;
  localparam logic [3:0] BC_BHI  = 4'd9;
  localparam logic [3:0] BC_BLOS = 4'd10;
  localparam logic [3:0] BC_BVC  = 4'd11;
  localparam logic [3:0] BC_BVS  = 4'd12;
  localparam logic [3:0] BC_BCC  = 4'd13;
  localparam logic [3:0] BC_BCS  = 4'd14;

  // Flag bit positions
  localparam int unsigned FL_N = 3;
  localparam int unsigned FL_Z = 2;
  localparam int unsigned FL_V = 1;
  localparam int unsigned FL_C = 0;

  localparam int unsigned IN_BITS  = 74;
  localparam int unsigned IN_BYTES = 80;
  localparam int unsigned OUT_BITS = 38;
  localparam int unsigned OUT_BYTES = 40;

  // Input beat, last field in the lowest bits
  typedef struct packed {
    logic signed [7:0] branch_offset;
    logic [15:0]       pc_in;
    logic [3:0]        branch_cond;
    logic [3:0]        code_mask;
    logic [3:0]        flags_in;
    logic [15:0]       dst_word;
    logic [15:0]       src_word;
    logic              byte_mode;
    logic [4:0]        cmd;
  } item_t;

  // ALU side of a result
  typedef struct packed {
    logic [3:0]  flags_out;
    logic        write_back;
    logic [15:0] result_word;
  } alu_res_t;

  // Branch side of a result
  typedef struct packed {
    logic [15:0] next_pc;
    logic        branch_taken;
  } br_res_t;

  // Output beat, last field in the lowest bits
  typedef struct packed {
    logic [15:0] next_pc;
    logic        branch_taken;
    logic [3:0]  flags_out;
    logic        write_back;
    logic [15:0] result_word;
  } result_t;

  // Truth table of each condition, indexed by the NZVC nibble
  function automatic logic [15:0] cond_bits(input logic [3:0] cond);
    logic [15:0] bits;
    unique case (cond)
      BC_BR:   bits = 16'hFFFF;
      BC_BNE:  bits = 16'h0F0F;
      BC_BEQ:  bits = 16'hF0F0;
      BC_BGE:  bits = 16'hCC33;
      BC_BLT:  bits = 16'h33CC;
      BC_BGT:  bits = 16'h0C03;
      BC_BLE:  bits = 16'hF3FC;
      BC_BPL:  bits = 16'h00FF;
      BC_BMI:  bits = 16'hFF00;
      BC_BHI:  bits = 16'h0505;
      BC_BLOS: bits = 16'hFAFA;
      BC_BVC:  bits = 16'h3333;
      BC_BVS:  bits = 16'hCCCC;
      BC_BCC:  bits = 16'h5555;
      BC_BCS:  bits = 16'hAAAA;
      default: bits = 16'h0000;
    endcase
    return bits;
  endfunction

endpackage

// File: src/sba_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_alu
// Result word, write-back flag and new NZVC for the two-operand, one-operand,
// shift, swap and condition-code groups. Purely combinational.
// ---------------------------------------------------------------------------
module sba_alu
  import sba_pkg::*;
(
  input  item_t    item,
  output alu_res_t res
);

  logic        bym;
  logic [15:0] s;
  logic [15:0] d;
  logic [15:0] mask;
  logic [15:0] sign;
  logic [16:0] sum_sd;
  logic [16:0] dif_sd;
  logic [16:0] dif_ds;
  logic        cin;
  logic [15:0] r;
  logic        wb;
  logic        nv;
  logic        cv;
  logic        arith;
  logic        shiftv;
  logic        n_bit;
  logic        z_bit;
  logic [3:0]  fout;
  logic [15:0] r_ext;

  // Byte mode does not apply to ADD, SUB and SWAB
  assign bym  = item.byte_mode &&
                !(item.cmd == CMD_ADD || item.cmd == CMD_SUB || item.cmd == CMD_SWAB);
  assign mask = bym ? 16'h00FF : 16'hFFFF;
  assign sign = bym ? 16'h0080 : 16'h8000;
  assign s    = item.src_word & mask;
  assign d    = item.dst_word & mask;
  assign cin  = item.flags_in[FL_C];

  assign sum_sd = {1'b0, s} + {1'b0, d};
  assign dif_sd = {1'b0, s} - {1'b0, d};
  assign dif_ds = {1'b0, d} - {1'b0, s};

  // Operation decode
  always_comb begin
    r      = 16'h0000;
    wb     = 1'b0;
    nv     = item.flags_in[FL_V];
    cv     = cin;
    arith  = 1'b1;
    shiftv = 1'b0;
    unique case (item.cmd)
      CMD_MOV: begin
        r = s; nv = 1'b0; wb = 1'b1;
      end
      CMD_CMP: begin
        r  = dif_sd[15:0] & mask;
        cv = dif_sd[16];
        nv = |(((s ^ d) & ~(d ^ r)) & sign);
      end
      CMD_BIT: begin
        r = s & d; nv = 1'b0;
      end
      CMD_BIC: begin
        r = d & ~s & mask; nv = 1'b0; wb = 1'b1;
      end
      CMD_BIS: begin
        r = d | s; nv = 1'b0; wb = 1'b1;
      end
      CMD_ADD: begin
        r  = sum_sd[15:0];
        cv = sum_sd[16];
        nv = |((~(s ^ d) & (d ^ r)) & sign);
        wb = 1'b1;
      end
      CMD_SUB: begin
        r  = dif_ds[15:0];
        cv = dif_ds[16];
        nv = |(((s ^ d) & (d ^ r)) & sign);
        wb = 1'b1;
      end
      CMD_CLR: begin
        r = 16'h0000; nv = 1'b0; cv = 1'b0; wb = 1'b1;
      end
      CMD_COM: begin
        r = ~d & mask; nv = 1'b0; cv = 1'b1; wb = 1'b1;
      end
      CMD_INC: begin
        r = (d + 16'd1) & mask; nv = (d == sign - 16'd1); wb = 1'b1;
      end
      CMD_DEC: begin
        r = (d - 16'd1) & mask; nv = (d == sign); wb = 1'b1;
      end
      CMD_NEG: begin
        r  = (16'd0 - d) & mask;
        cv = (r != 16'd0);
        nv = (r == sign);
        wb = 1'b1;
      end
      CMD_ADC: begin
        r  = (d + {15'd0, cin}) & mask;
        nv = cin && (d == sign - 16'd1);
        cv = cin && (d == mask);
        wb = 1'b1;
      end
      CMD_SBC: begin
        r  = (d - {15'd0, cin}) & mask;
        nv = cin && (d == sign);
        cv = cin && (d == 16'd0);
        wb = 1'b1;
      end
      CMD_TST: begin
        r = d; nv = 1'b0; cv = 1'b0;
      end
      CMD_ROR: begin
        r  = (d >> 1) | (cin ? sign : 16'h0000);
        cv = d[0]; shiftv = 1'b1; wb = 1'b1;
      end
      CMD_ROL: begin
        r  = ((d << 1) & mask) | {15'd0, cin};
        cv = |(d & sign); shiftv = 1'b1; wb = 1'b1;
      end
      CMD_ASR: begin
        r  = (d >> 1) | (d & sign);
        cv = d[0]; shiftv = 1'b1; wb = 1'b1;
      end
      CMD_ASL: begin
        r  = (d << 1) & mask;
        cv = |(d & sign); shiftv = 1'b1; wb = 1'b1;
      end
      CMD_SWAB: begin
        r = {d[7:0], d[15:8]}; wb = 1'b1; arith = 1'b0;
        nv = 1'b0; cv = 1'b0;
      end
      default: begin
        arith = 1'b0;
      end
    endcase
  end

  assign n_bit = |(r & sign);
  assign z_bit = ((r & mask) == 16'h0000);

  // Assemble new condition codes
  always_comb begin
    fout = item.flags_in;
    if (arith) begin
      fout = {n_bit, z_bit, (shiftv ? (n_bit ^ cv) : nv), cv};
    end else if (item.cmd == CMD_SWAB) begin
      fout = {r[7], (r[7:0] == 8'h00), 1'b0, 1'b0};
    end else if (item.cmd == CMD_CCC) begin
      fout = item.flags_in & ~item.code_mask;
    end else if (item.cmd == CMD_SCC) begin
      fout = item.flags_in | item.code_mask;
    end
  end

  // Sign-extend byte results
  assign r_ext = (bym && r[7]) ? (r | 16'hFF00) : r;

  assign res.result_word = r_ext;
  assign res.write_back  = wb;
  assign res.flags_out   = fout;

endmodule

// File: src/sba_branch.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_branch
// Branch condition test against the incoming flags and target PC adder.
// ---------------------------------------------------------------------------
module sba_branch
  import sba_pkg::*;
(
  input  item_t   item,
  output br_res_t res
);

  logic [15:0] cbits;
  logic        taken;
  logic [15:0] disp;

  assign cbits = cond_bits(item.branch_cond);
  assign taken = (item.cmd == CMD_BRANCH) && cbits[item.flags_in];

  // Word offset, sign-extended and doubled
  assign disp = {{7{item.branch_offset[7]}}, item.branch_offset, 1'b0};

  assign res.branch_taken = taken;
  assign res.next_pc      = taken ? (item.pc_in + disp) : item.pc_in;

endmodule

// File: src/sixteen_bit_alu_condition_codes.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sixteen_bit_alu_condition_codes
// Execute stage: operand register, single-pass ALU and branch logic, result
// register. One instruction per cycle while m_axis is not stalled.
// ---------------------------------------------------------------------------
//  Channel   Dir  Width  Contents
//  s_axis    in   80     instruction operands, flags, branch fields
//  m_axis    out  40     result word, write-back, flags, branch, next PC
//
//  A beat passes from the operand register to the result register; one
//  beat is taken every cycle while m_axis is not stalled, set by the single
//  ALU pass between operand and result registers. Reset empties both
//  registers. A stall on m_axis holds the result register; the operand
//  register keeps taking beats until it is full behind it.
// ---------------------------------------------------------------------------
`include "sixteen_bit_alu_condition_codes_macros.svh"

module sixteen_bit_alu_condition_codes
  import sba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // low to high: cmd[4:0], byte_mode[5], src_word[21:6], dst_word[37:22],
  // flags_in[41:38], code_mask[45:42], branch_cond[49:46], pc_in[65:50],
  // branch_offset[73:66], zero fill[79:74]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // low to high: result_word[15:0], write_back[16], flags_out[20:17],
  // branch_taken[21], next_pc[37:22], zero fill[39:38]
  output logic [39:0] m_axis_tdata
);

  logic     in_valid;
  item_t    in_item;
  logic     out_valid;
  result_t  out_res;
  logic     out_adv;
  alu_res_t alu_res;
  br_res_t  br_res;

  // Result register moves when empty or drained
  assign out_adv       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_adv;

  // Operand register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= item_t'(s_axis_tdata[IN_BITS-1:0]);
    end
  end

  sba_alu u_alu (
    .item (in_item),
    .res  (alu_res)
  );

  sba_branch u_branch (
    .item (in_item),
    .res  (br_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid) begin
      out_res.result_word  <= alu_res.result_word;
      out_res.write_back   <= alu_res.write_back;
      out_res.flags_out    <= alu_res.flags_out;
      out_res.branch_taken <= br_res.branch_taken;
      out_res.next_pc      <= br_res.next_pc;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_BYTES - OUT_BITS){1'b0}}, out_res};

  // Checks
  `SBA_ASSERT_NEXT(a_beat_moves_on, in_valid && out_adv, out_valid,
    "operand beat did not reach the result register")
  `SBA_ASSERT_NEXT(a_stalled_beat_kept, in_valid && !out_adv, in_valid,
    "operand beat lost while the result register was stalled")
  `SBA_ASSERT_NOW(a_branch_no_store, m_axis_tvalid && m_axis_tdata[21],
    !m_axis_tdata[16], "taken branch marked for write-back")

endmodule
